// ----- rtl/sli_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned MAX_LISTS    = 256;
  localparam int unsigned MAX_LIST_LEN = 32;

  localparam int unsigned ROW_W  = $clog2(MAX_LISTS);
  localparam int unsigned CNT_W  = $clog2(MAX_LISTS + 1);
  localparam int unsigned COL_W  = (MAX_LIST_LEN > 1) ? $clog2(MAX_LIST_LEN) : 1;
  localparam int unsigned LEN_W  = $clog2(MAX_LIST_LEN + 1);
  localparam int unsigned ADDR_W = ROW_W + COL_W;
  localparam int unsigned STORE_DEPTH = MAX_LISTS * (2 ** COL_W);

  localparam int unsigned KIND_W = 2;
  localparam int unsigned SITE_W = 8;
  localparam int unsigned NS_W   = 6;
  localparam int unsigned IDX_W  = 8;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_QUERY   = 2'd0,
    KIND_REPLACE = 2'd1,
    KIND_RESTORE = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  typedef enum logic [STAT_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_ADDED    = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LEN_RD,
    S_LEN_CHK,
    S_EL_RD,
    S_EL_CHK,
    S_COPY_ADD,
    S_COPY_REP
  } state_e;

  typedef struct packed {
    logic    push;
    logic    restore;
    logic    pend_clr;
    logic    row_zero;
    logic    row_next;
    logic    row_new;
    logic    col_zero;
    logic    col_next;
    logic    store_wr;
    logic    len_commit;
    logic    cnt_inc;
    logic    res_valid;
    logic    res_use_row;
    status_e res_status;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  term;
    logic  ovf;
    logic  plen_zero;
    logic  len_match;
    logic  el_match;
    logic  col_last;
    logic  copy_done;
    logic  row_last;
    logic  full;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/site_list_interning_table_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// site_list_interning_table_unit
// Interning table of site lists: buffers elements, searches, appends, replaces row 0.
//
// Channel   Dir  Handshake                 Payload
// command   in   start & !busy             kind_i, site_i
// result    out  result_valid_o (1 cycle)  list_index_o, status_o
// config    in   APB psel/penable/pwrite   num_sites at address 0
//
// Element, restore and ignored items are taken in S_IDLE; busy stays low.
// Query terminator: a length read and check per row searched and an element
// read and check per element compared, bound by the single read port of the
// list store, then a copy to append a new list unless full. Replacement: a
// copy into row 0. Over-long: answered in S_IDLE. Result in next cycle.
// After reset row 0 holds the default list; no clearing pass is needed.
// ----------------------------------------------------------------------------
module site_list_interning_table_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [sli_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [sli_pkg::SITE_W-1:0]  site_i,
  output logic                             result_valid_o,
  output logic [sli_pkg::IDX_W-1:0]        list_index_o,
  output logic [sli_pkg::STAT_W-1:0]       status_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import sli_pkg::*;

  logic [NS_W-1:0] num_sites_q;
  cmd_t            cmd;
  sts_t            sts;
  logic            cfg_wr;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == 1'b0);
  assign cfg_wr  = psel && penable && pwrite && reg_sel;
  assign prdata  = reg_sel ? 32'(num_sites_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_sites_q <= NS_W'(1);
    end else if (cfg_wr) begin
      num_sites_q <= pwdata[NS_W-1:0];
    end
  end

  sli_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  sli_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .kind_i         (kind_i),
    .site_i         (site_i),
    .num_sites_i    (num_sites_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .list_index_o   (list_index_o),
    .status_o       (status_o)
  );

  a_err_index_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == ST_FULL || status_o == ST_TOO_LONG)
      |-> list_index_o == '0)
    else $error("error result with nonzero index");

  a_added_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == ST_ADDED |-> list_index_o != '0)
    else $error("added list at index zero");

  a_result_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy || start))
    else $error("result without an item in flight");

endmodule
`default_nettype wire

// ----- rtl/sli_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_ctrl
// Sequencer: element buffering, row-by-row search, row copy and result.
// ----------------------------------------------------------------------------
module sli_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  sli_pkg::sts_t     sts_i,
  output sli_pkg::cmd_t     cmd_o,
  output logic              busy_o
);
  import sli_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && sts_i.term && !sts_i.ovf) begin
          if (sts_i.kind == KIND_QUERY) begin
            state_d = S_LEN_RD;
          end else if (sts_i.kind == KIND_REPLACE) begin
            state_d = S_COPY_REP;
          end
        end
      end
      S_LEN_RD: state_d = S_LEN_CHK;
      S_LEN_CHK, S_EL_CHK: begin
        if ((state_q == S_LEN_CHK && !sts_i.len_match) ||
            (state_q == S_EL_CHK && !sts_i.el_match)) begin
          if (!sts_i.row_last) begin
            state_d = S_LEN_RD;
          end else if (sts_i.full) begin
            state_d = S_IDLE;
          end else begin
            state_d = S_COPY_ADD;
          end
        end else if ((state_q == S_LEN_CHK && sts_i.plen_zero) ||
                     (state_q == S_EL_CHK && sts_i.col_last)) begin
          state_d = S_IDLE;
        end else begin
          state_d = S_EL_RD;
        end
      end
      S_EL_RD: state_d = S_EL_CHK;
      S_COPY_ADD, S_COPY_REP: begin
        if (sts_i.copy_done) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o = '0;
    cmd_o.res_status = ST_FOUND;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (sts_i.kind)
            KIND_NONE: ;
            KIND_RESTORE: begin
              cmd_o.restore  = 1'b1;
              cmd_o.pend_clr = 1'b1;
            end
            KIND_QUERY, KIND_REPLACE: begin
              if (!sts_i.term) begin
                cmd_o.push = 1'b1;
              end else if (sts_i.ovf) begin
                cmd_o.res_valid  = 1'b1;
                cmd_o.res_status = ST_TOO_LONG;
                cmd_o.pend_clr   = 1'b1;
              end else begin
                cmd_o.row_zero = 1'b1;
                cmd_o.col_zero = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_LEN_RD, S_EL_RD: ;
      S_LEN_CHK, S_EL_CHK: begin
        if ((state_q == S_LEN_CHK && !sts_i.len_match) ||
            (state_q == S_EL_CHK && !sts_i.el_match)) begin
          if (!sts_i.row_last) begin
            cmd_o.row_next = 1'b1;
          end else if (sts_i.full) begin
            cmd_o.res_valid  = 1'b1;
            cmd_o.res_status = ST_FULL;
            cmd_o.pend_clr   = 1'b1;
          end else begin
            cmd_o.row_new  = 1'b1;
            cmd_o.col_zero = 1'b1;
          end
        end else if ((state_q == S_LEN_CHK && sts_i.plen_zero) ||
                     (state_q == S_EL_CHK && sts_i.col_last)) begin
          cmd_o.res_valid   = 1'b1;
          cmd_o.res_use_row = 1'b1;
          cmd_o.res_status  = ST_FOUND;
          cmd_o.pend_clr    = 1'b1;
        end else if (state_q == S_LEN_CHK) begin
          cmd_o.col_zero = 1'b1;
        end else begin
          cmd_o.col_next = 1'b1;
        end
      end
      S_COPY_ADD, S_COPY_REP: begin
        if (sts_i.copy_done) begin
          cmd_o.len_commit  = 1'b1;
          cmd_o.cnt_inc     = (state_q == S_COPY_ADD);
          cmd_o.res_valid   = 1'b1;
          cmd_o.res_use_row = 1'b1;
          cmd_o.res_status  = (state_q == S_COPY_ADD) ? ST_ADDED : ST_FOUND;
          cmd_o.pend_clr    = 1'b1;
        end else begin
          cmd_o.store_wr = 1'b1;
          cmd_o.col_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/sli_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sli_dp
// Pending list, list store, length store, counters and result register.
// ----------------------------------------------------------------------------
module sli_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [sli_pkg::KIND_W-1:0]  kind_i,
  input  wire logic [sli_pkg::SITE_W-1:0]  site_i,
  input  wire logic [sli_pkg::NS_W-1:0]    num_sites_i,
  input  sli_pkg::cmd_t                    cmd_i,
  output sli_pkg::sts_t                    sts_o,
  output logic                             result_valid_o,
  output logic [sli_pkg::IDX_W-1:0]        list_index_o,
  output logic [sli_pkg::STAT_W-1:0]       status_o
);
  import sli_pkg::*;

  logic [SITE_W-1:0] pend_q [MAX_LIST_LEN];
  logic [LEN_W-1:0]  plen_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  count_q;
  logic [LEN_W-1:0]  len0_q;
  logic              dflt_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [LEN_W-1:0]  col_q, col_d;

  logic [SITE_W-1:0] store_mem [STORE_DEPTH];
  logic [LEN_W-1:0]  len_mem [MAX_LISTS];
  logic [SITE_W-1:0] srd_q;
  logic [LEN_W-1:0]  lrd_q;

  logic              res_valid_q;
  logic [IDX_W-1:0]  idx_q;
  logic [STAT_W-1:0] stat_q;

  logic [ADDR_W-1:0] addr;
  logic [COL_W-1:0]  col_idx;
  logic [LEN_W-1:0]  cur_len;
  logic [LEN_W-1:0]  dflt_len;
  logic [SITE_W-1:0] cur_el;

  assign col_idx  = col_q[COL_W-1:0];
  assign addr     = {row_q, col_idx};
  assign cur_len  = (row_q == '0) ? len0_q : lrd_q;
  assign cur_el   = (row_q == '0 && dflt_q) ? (SITE_W'(col_q) + SITE_W'(1)) : srd_q;
  assign dflt_len = (32'(num_sites_i) > 32'(MAX_LIST_LEN)) ? LEN_W'(MAX_LIST_LEN)
                                                          : LEN_W'(num_sites_i);

  always_comb begin
    sts_o.kind      = kind_e'(kind_i);
    sts_o.term      = (site_i == '0);
    sts_o.ovf       = ovf_q;
    sts_o.plen_zero = (plen_q == '0);
    sts_o.len_match = (cur_len == plen_q);
    sts_o.el_match  = (cur_el == pend_q[col_idx]);
    sts_o.col_last  = ((col_q + LEN_W'(1)) == plen_q);
    sts_o.copy_done = (col_q == plen_q);
    sts_o.row_last  = ((CNT_W'(row_q) + CNT_W'(1)) == count_q);
    sts_o.full      = (count_q == CNT_W'(MAX_LISTS));
  end

  always_comb begin
    row_d = row_q;
    priority if (cmd_i.row_zero) begin
      row_d = '0;
    end else if (cmd_i.row_next) begin
      row_d = row_q + ROW_W'(1);
    end else if (cmd_i.row_new) begin
      row_d = count_q[ROW_W-1:0];
    end
    col_d = col_q;
    priority if (cmd_i.col_zero) begin
      col_d = '0;
    end else if (cmd_i.col_next) begin
      col_d = col_q + LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plen_q      <= '0;
      ovf_q       <= 1'b0;
      count_q     <= CNT_W'(1);
      len0_q      <= LEN_W'(1);
      dflt_q      <= 1'b1;
      row_q       <= '0;
      col_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      row_q       <= row_d;
      col_q       <= col_d;
      res_valid_q <= cmd_i.res_valid;
      if (cmd_i.pend_clr) begin
        plen_q <= '0;
        ovf_q  <= 1'b0;
      end else if (cmd_i.push) begin
        if (plen_q < LEN_W'(MAX_LIST_LEN)) begin
          plen_q <= plen_q + LEN_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.restore) begin
        count_q <= CNT_W'(1);
        len0_q  <= dflt_len;
        dflt_q  <= 1'b1;
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.len_commit && row_q == '0) begin
        len0_q <= plen_q;
        dflt_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && plen_q < LEN_W'(MAX_LIST_LEN)) begin
      pend_q[plen_q[COL_W-1:0]] <= site_i;
    end
    if (cmd_i.res_valid) begin
      idx_q  <= cmd_i.res_use_row ? IDX_W'(row_q) : '0;
      stat_q <= cmd_i.res_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store_wr) begin
      store_mem[addr] <= pend_q[col_idx];
    end
    srd_q <= store_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.len_commit && row_q != '0) begin
      len_mem[row_q] <= plen_q;
    end
    lrd_q <= len_mem[row_q];
  end

  assign result_valid_o = res_valid_q;
  assign list_index_o   = idx_q;
  assign status_o       = stat_q;

endmodule
`default_nettype wire
